FILE: src/assert_macros.svh
// assertion macros used by the checker file plm_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: src/plm_pkg.sv
// types and constants of the pinned lru frame manager
`default_nettype none
package plm_pkg;
    localparam int unsigned NUM_FRAMES_DEF = 16;
    localparam int unsigned IDX_W = 6;
    localparam logic [4:0] FIU_RESET = 5'd16;

    typedef enum logic [1:0] {
        MODE_PIN   = 2'd0,
        MODE_TEMP  = 2'd1,
        MODE_UNPIN = 2'd2,
        MODE_DIRTY = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_HIT,
        OP_LOAD,
        OP_UNPIN,
        OP_DIRTY
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  table_id;
        logic [23:0] page;
        logic [6:0]  lim;
    } t_req;

    typedef struct packed {
        logic             hit_f;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] hit_rank;
        logic             emp_f;
        logic [IDX_W-1:0] emp_idx;
        logic             vic_f;
        logic [IDX_W-1:0] vic_idx;
        logic [IDX_W-1:0] vic_rank;
        logic             vic_dirty;
        logic             vic_temp;
        logic [7:0]       vic_table;
        logic [23:0]      vic_page;
    } t_cand;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] ref_rank;
        logic [IDX_W-1:0] new_rank;
        logic             shift;
        logic             temp;
        logic [7:0]       table_id;
        logic [23:0]      page;
    } t_upd;
endpackage
`default_nettype wire

FILE: src/pinned_lru_frame_manager_unit.sv
// top level of the pinned lru frame manager
//
// command channel: an item is taken when start is high and busy is low.
// mode 0 pins a table page, 1 pins a new temp page, 2 unpins a frame,
// 3 marks a frame dirty. each item gives one result, shown for exactly one
// cycle with o_valid high; the receiver cannot stall it.
// pin requests run a search through a row of NUM_FRAMES cells, one cell per
// cycle; busy stays high until the result, so a new item waits for it.
// unpin and mark-dirty skip the search and go straight to the result state.
// frames_in_use is written over the apb port at addresses 0 to 3; the user
// must write it only while idle, which the block itself does not enforce.
// reset empties every frame, clears the recency order and temp slot counter
// and sets frames_in_use to 16; no clearing pass is needed.
`default_nettype none
module pinned_lru_frame_manager_unit #(
    parameter int unsigned NUM_FRAMES = plm_pkg::NUM_FRAMES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_table_id,
    input  wire logic [23:0] i_page_number,
    input  wire logic [3:0]  i_frame_index,
    output logic             o_valid,
    output logic [3:0]       o_frame,
    output logic             o_hit,
    output logic             o_evicted,
    output logic             o_write_back,
    output logic             o_victim_is_temp,
    output logic [7:0]       o_victim_table,
    output logic [23:0]      o_victim_location,
    output logic             o_all_pinned,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int unsigned CW = $clog2(NUM_FRAMES);
    localparam int unsigned LW = $clog2(NUM_FRAMES + 1);
    localparam int unsigned IW = plm_pkg::IDX_W;

    plm_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_len, n_len;
    logic [23:0] r_tcnt, n_tcnt;
    logic [4:0] r_cfg;
    plm_pkg::t_mode r_mode;
    logic [7:0] r_tab;
    logic [23:0] r_pg;
    logic [3:0] r_fi;
    plm_pkg::t_req req;
    plm_pkg::t_upd upd;
    plm_pkg::t_cand w_cand [NUM_FRAMES+1];
    plm_pkg::t_cand fin;
    logic [6:0] lim;
    logic accept;

    logic r_valid, n_valid;
    logic [3:0] r_frame, n_frame;
    logic r_hit, n_hit, r_ev, n_ev, r_wb, n_wb, r_vt, n_vt, r_ap, n_ap;
    logic [7:0] r_vtab, n_vtab;
    logic [23:0] r_vloc, n_vloc;

    assign accept = start && !busy;
    assign busy = r_state != plm_pkg::ST_IDLE;
    assign pready = 1'b1;
    assign prdata = {27'b0, r_cfg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cfg <= plm_pkg::FIU_RESET;
        else if (psel && penable && pwrite && !paddr[2]) r_cfg <= pwdata[4:0];
    end

    always_comb begin
        if (r_cfg == 5'd0) lim = 7'd1;
        else if ({2'b0, r_cfg} > 7'(NUM_FRAMES)) lim = 7'(NUM_FRAMES);
        else lim = {2'b0, r_cfg};
        req.mode = r_mode;
        req.table_id = r_tab;
        req.page = r_pg;
        req.lim = lim;
    end

    assign w_cand[0] = '0;
    for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_cell
        plm_cell #(.CELL_ID(k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_req  (req),
            .i_cand (w_cand[k]),
            .i_upd  (upd),
            .o_cand (w_cand[k+1])
        );
    end
    assign fin = w_cand[NUM_FRAMES];

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_len = r_len;
        n_tcnt = r_tcnt;
        upd = '0;
        upd.op = plm_pkg::OP_NONE;
        n_valid = 1'b0;
        n_frame = '0;
        n_hit = 1'b0;
        n_ev = 1'b0;
        n_wb = 1'b0;
        n_vt = 1'b0;
        n_ap = 1'b0;
        n_vtab = '0;
        n_vloc = '0;
        case (r_state)
            plm_pkg::ST_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    if (i_mode == plm_pkg::MODE_UNPIN || i_mode == plm_pkg::MODE_DIRTY)
                        n_state = plm_pkg::ST_RESP;
                    else
                        n_state = plm_pkg::ST_SCAN;
                end
            end
            plm_pkg::ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                // candidate leaves the last cell after one pass down the row
                if (r_cnt == CW'(NUM_FRAMES - 1)) n_state = plm_pkg::ST_RESP;
            end
            plm_pkg::ST_RESP: begin
                n_state = plm_pkg::ST_IDLE;
                n_valid = 1'b1;
                upd.temp = r_mode == plm_pkg::MODE_TEMP;
                upd.table_id = upd.temp ? 8'd0 : r_tab;
                upd.page = upd.temp ? 24'd0 : r_pg;
                if (r_mode == plm_pkg::MODE_UNPIN || r_mode == plm_pkg::MODE_DIRTY) begin
                    upd.op = (r_mode == plm_pkg::MODE_UNPIN) ? plm_pkg::OP_UNPIN
                                                             : plm_pkg::OP_DIRTY;
                    upd.idx = IW'(r_fi);
                    n_frame = r_fi;
                end else if (r_mode == plm_pkg::MODE_PIN && fin.hit_f) begin
                    upd.op = plm_pkg::OP_HIT;
                    upd.idx = fin.hit_idx;
                    upd.shift = 1'b1;
                    upd.ref_rank = fin.hit_rank;
                    upd.new_rank = IW'(r_len - 1'b1);
                    n_frame = fin.hit_idx[3:0];
                    n_hit = 1'b1;
                end else if (fin.emp_f) begin
                    upd.op = plm_pkg::OP_LOAD;
                    upd.idx = fin.emp_idx;
                    upd.new_rank = IW'(r_len);
                    n_len = r_len + 1'b1;
                    n_frame = fin.emp_idx[3:0];
                end else if (fin.vic_f) begin
                    upd.op = plm_pkg::OP_LOAD;
                    upd.idx = fin.vic_idx;
                    upd.shift = 1'b1;
                    upd.ref_rank = fin.vic_rank;
                    upd.new_rank = IW'(r_len - 1'b1);
                    n_frame = fin.vic_idx[3:0];
                    n_ev = 1'b1;
                    if (fin.vic_temp) begin
                        n_wb = 1'b1;
                        n_vt = 1'b1;
                        n_vloc = r_tcnt;
                        n_tcnt = r_tcnt + 1'b1;
                    end else begin
                        n_wb = fin.vic_dirty;
                        n_vtab = fin.vic_table;
                        n_vloc = fin.vic_page;
                    end
                end else begin
                    n_ap = 1'b1;
                end
            end
            default: n_state = plm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plm_pkg::ST_IDLE;
            r_cnt <= '0;
            r_len <= '0;
            r_tcnt <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_len <= n_len;
            r_tcnt <= n_tcnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= plm_pkg::t_mode'(i_mode);
            r_tab <= i_table_id;
            r_pg <= i_page_number;
            r_fi <= i_frame_index;
        end
        r_frame <= n_frame;
        r_hit <= n_hit;
        r_ev <= n_ev;
        r_wb <= n_wb;
        r_vt <= n_vt;
        r_ap <= n_ap;
        r_vtab <= n_vtab;
        r_vloc <= n_vloc;
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;
    assign o_hit = r_hit;
    assign o_evicted = r_ev;
    assign o_write_back = r_wb;
    assign o_victim_is_temp = r_vt;
    assign o_victim_table = r_vtab;
    assign o_victim_location = r_vloc;
    assign o_all_pinned = r_ap;
endmodule
`default_nettype wire

FILE: src/plm_cell.sv
// one frame cell: holds a frame's state and passes the search candidate on
`default_nettype none
module plm_cell #(
    parameter int unsigned CELL_ID = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire plm_pkg::t_req  i_req,
    input  wire plm_pkg::t_cand i_cand,
    input  wire plm_pkg::t_upd  i_upd,
    output plm_pkg::t_cand      o_cand
);
    localparam logic [plm_pkg::IDX_W-1:0] MY_IDX = plm_pkg::IDX_W'(CELL_ID);

    logic r_valid, r_pinned, r_dirty, r_temp;
    logic n_valid, n_pinned, n_dirty, n_temp;
    logic [7:0] r_table, n_table;
    logic [23:0] r_page, n_page;
    logic [plm_pkg::IDX_W-1:0] r_rank, n_rank;
    plm_pkg::t_cand r_cand, n_cand;
    logic in_pool, sel, dec;

    always_comb begin
        in_pool = 7'(CELL_ID) < i_req.lim;
        n_cand = i_cand;
        if (r_valid && !r_temp && i_req.mode == plm_pkg::MODE_PIN && !i_cand.hit_f
            && r_table == i_req.table_id && r_page == i_req.page) begin
            n_cand.hit_f = 1'b1;
            n_cand.hit_idx = MY_IDX;
            n_cand.hit_rank = r_rank;
        end
        if (!r_valid && in_pool && !i_cand.emp_f) begin
            n_cand.emp_f = 1'b1;
            n_cand.emp_idx = MY_IDX;
        end
        if (r_valid && !r_pinned && in_pool && (!i_cand.vic_f || r_rank < i_cand.vic_rank)) begin
            n_cand.vic_f = 1'b1;
            n_cand.vic_idx = MY_IDX;
            n_cand.vic_rank = r_rank;
            n_cand.vic_dirty = r_dirty;
            n_cand.vic_temp = r_temp;
            n_cand.vic_table = r_table;
            n_cand.vic_page = r_page;
        end
    end

    always_comb begin
        sel = i_upd.idx == MY_IDX;
        // frames behind the moved one step forward in the order
        dec = r_valid && i_upd.shift && r_rank > i_upd.ref_rank;
        n_valid = r_valid;
        n_pinned = r_pinned;
        n_dirty = r_dirty;
        n_temp = r_temp;
        n_table = r_table;
        n_page = r_page;
        n_rank = r_rank;
        case (i_upd.op)
            plm_pkg::OP_HIT: begin
                if (sel) begin
                    n_pinned = 1'b1;
                    n_rank = i_upd.new_rank;
                end else if (dec) begin
                    n_rank = r_rank - 1'b1;
                end
            end
            plm_pkg::OP_LOAD: begin
                if (sel) begin
                    n_valid = 1'b1;
                    n_pinned = 1'b1;
                    n_dirty = 1'b0;
                    n_temp = i_upd.temp;
                    n_table = i_upd.table_id;
                    n_page = i_upd.page;
                    n_rank = i_upd.new_rank;
                end else if (dec) begin
                    n_rank = r_rank - 1'b1;
                end
            end
            plm_pkg::OP_UNPIN: if (sel && r_valid) n_pinned = 1'b0;
            plm_pkg::OP_DIRTY: if (sel && r_valid) n_dirty = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pinned <= 1'b0;
            r_dirty <= 1'b0;
            r_temp <= 1'b0;
            r_rank <= '0;
            r_cand <= '0;
        end else begin
            r_valid <= n_valid;
            r_pinned <= n_pinned;
            r_dirty <= n_dirty;
            r_temp <= n_temp;
            r_rank <= n_rank;
            r_cand <= n_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        r_table <= n_table;
        r_page <= n_page;
    end

    assign o_cand = r_cand;
endmodule
`default_nettype wire

FILE: src/plm_checker.sv
// port-level checker for the frame manager and its bind
`default_nettype none
`include "assert_macros.svh"
module plm_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire logic o_hit,
    input wire logic o_evicted,
    input wire logic o_write_back,
    input wire logic o_all_pinned
);
    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accept without busy")
    `ASSERT_NEVER(a_hit_evict, i_clk, i_rst_n, o_valid && o_hit && o_evicted, "hit and evict")
    `ASSERT_NEVER(a_wb_evict, i_clk, i_rst_n, o_write_back && !o_evicted, "write-back w/o victim")
    `ASSERT_NEVER(a_pinned, i_clk, i_rst_n, o_all_pinned && (o_hit || o_evicted), "failed item")
endmodule

bind pinned_lru_frame_manager_unit plm_checker u_plm_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .o_valid(o_valid),
    .o_hit(o_hit),
    .o_evicted(o_evicted),
    .o_write_back(o_write_back),
    .o_all_pinned(o_all_pinned)
);
`default_nettype wire

FILE: verif/tb_top.sv
// self-checking testbench for the pinned lru frame manager
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFR = 16;
    localparam int DRAIN = NFR + 8;
    localparam int LIMIT = 400000;
    localparam int N_RAND = 1200;

    typedef struct packed {
        logic [3:0]  frame;
        logic        hit;
        logic        evicted;
        logic        write_back;
        logic        victim_is_temp;
        logic [7:0]  victim_table;
        logic [23:0] victim_location;
        logic        all_pinned;
    } t_res;

    typedef struct {
        bit             is_cfg;
        plm_pkg::t_mode mode;
        logic [7:0]     tab;
        logic [23:0]    pg;
        logic [3:0]     fi;
        logic [4:0]     cfg;
        bit             typed;
        t_res           res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] i_mode = '0;
    logic [7:0] i_table_id = '0;
    logic [23:0] i_page_number = '0;
    logic [3:0] i_frame_index = '0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire busy, o_valid, pready;
    wire [3:0] o_frame;
    wire o_hit, o_evicted, o_write_back, o_victim_is_temp, o_all_pinned;
    wire [7:0] o_victim_table;
    wire [23:0] o_victim_location;
    wire [31:0] prdata;

    pinned_lru_frame_manager_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_table_id(i_table_id), .i_page_number(i_page_number),
        .i_frame_index(i_frame_index), .o_valid(o_valid), .o_frame(o_frame),
        .o_hit(o_hit), .o_evicted(o_evicted), .o_write_back(o_write_back),
        .o_victim_is_temp(o_victim_is_temp), .o_victim_table(o_victim_table),
        .o_victim_location(o_victim_location), .o_all_pinned(o_all_pinned),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the pool
    logic [4:0]  pool_size;
    bit          fr_valid[NFR], fr_pinned[NFR], fr_dirty[NFR], fr_temp[NFR];
    logic [7:0]  fr_table[NFR];
    logic [23:0] fr_page[NFR];
    int          lru_list[$];
    logic [23:0] temp_slot;

    t_res pending[$];
    t_row rows[$];
    int   n_err = 0;
    int   n_cyc = 0;

    function automatic void touch_frame(int f);
        foreach (lru_list[k]) if (lru_list[k] == f) begin
            lru_list.delete(k);
            break;
        end
        lru_list.push_back(f);
    endfunction

    function automatic t_res predict_frame(plm_pkg::t_mode m, logic [7:0] tab,
                                          logic [23:0] pg, logic [3:0] fi);
        t_res r;
        int lim, f;
        r = '0;
        if (m == plm_pkg::MODE_UNPIN || m == plm_pkg::MODE_DIRTY) begin
            r.frame = fi;
            if (fr_valid[fi]) begin
                if (m == plm_pkg::MODE_UNPIN) fr_pinned[fi] = 0;
                else fr_dirty[fi] = 1;
            end
            return r;
        end
        if (m == plm_pkg::MODE_PIN) begin
            for (int i = 0; i < NFR; i++) begin
                if (fr_valid[i] && !fr_temp[i] && fr_table[i] == tab && fr_page[i] == pg) begin
                    fr_pinned[i] = 1;
                    touch_frame(i);
                    r.frame = 4'(i);
                    r.hit = 1;
                    return r;
                end
            end
        end
        lim = (pool_size == 0) ? 1 : (pool_size > NFR) ? NFR : pool_size;
        f = -1;
        for (int i = 0; i < lim; i++) if (!fr_valid[i]) begin
            f = i;
            break;
        end
        if (f < 0) begin
            foreach (lru_list[k]) begin
                int v;
                v = lru_list[k];
                if (v < lim && fr_valid[v] && !fr_pinned[v]) begin
                    f = v;
                    r.evicted = 1;
                    if (fr_temp[v]) begin
                        r.write_back = 1;
                        r.victim_is_temp = 1;
                        r.victim_location = temp_slot;
                        temp_slot = temp_slot + 24'd1;
                    end else begin
                        r.write_back = fr_dirty[v];
                        r.victim_table = fr_table[v];
                        r.victim_location = fr_page[v];
                    end
                    lru_list.delete(k);
                    break;
                end
            end
        end
        if (f < 0) begin
            r.all_pinned = 1;
            return r;
        end
        fr_valid[f] = 1;
        fr_pinned[f] = 1;
        fr_dirty[f] = 0;
        fr_temp[f] = (m == plm_pkg::MODE_TEMP);
        fr_table[f] = (m == plm_pkg::MODE_TEMP) ? 8'd0 : tab;
        fr_page[f] = (m == plm_pkg::MODE_TEMP) ? 24'd0 : pg;
        touch_frame(f);
        r.frame = 4'(f);
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending.size() == 0) begin
                $error("result with no item outstanding");
                n_err++;
            end else begin
                t_res e;
                e = pending.pop_front();
                if (o_frame !== e.frame) begin
                    $error("frame exp %0d got %0d", e.frame, o_frame); n_err++;
                end
                if (o_hit !== e.hit) begin
                    $error("hit exp %0d got %0d", e.hit, o_hit); n_err++;
                end
                if (o_evicted !== e.evicted) begin
                    $error("evicted exp %0d got %0d", e.evicted, o_evicted); n_err++;
                end
                if (o_write_back !== e.write_back) begin
                    $error("write_back exp %0d got %0d", e.write_back, o_write_back);
                    n_err++;
                end
                if (o_victim_is_temp !== e.victim_is_temp) begin
                    $error("victim_is_temp exp %0d got %0d", e.victim_is_temp,
                           o_victim_is_temp);
                    n_err++;
                end
                if (o_victim_table !== e.victim_table) begin
                    $error("victim_table exp %0d got %0d", e.victim_table, o_victim_table);
                    n_err++;
                end
                if (o_victim_location !== e.victim_location) begin
                    $error("victim_location exp %0h got %0h", e.victim_location,
                           o_victim_location);
                    n_err++;
                end
                if (o_all_pinned !== e.all_pinned) begin
                    $error("all_pinned exp %0d got %0d", e.all_pinned, o_all_pinned);
                    n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cyc <= n_cyc + 1;
        if (n_cyc > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_idle();
        if (start) begin
            @(posedge i_clk);
            start <= 1'b0;
        end
        while (pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_pool_size(logic [4:0] v);
        wait_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {27'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        pool_size = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // holds start until the item is taken, then maybe idles
    task automatic send_item(plm_pkg::t_mode m, logic [7:0] tab, logic [23:0] pg,
                             logic [3:0] fi, bit typed, t_res tr, bit idle_after);
        t_res r;
        start <= 1'b1;
        i_mode <= m;
        i_table_id <= tab;
        i_page_number <= pg;
        i_frame_index <= fi;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = predict_frame(m, tab, pg, fi);
        pending.push_back(typed ? tr : r);
        if (idle_after) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    function automatic void add_item(plm_pkg::t_mode m, logic [7:0] tab, logic [23:0] pg,
                                     logic [3:0] fi);
        t_row w;
        w.is_cfg = 0; w.mode = m; w.tab = tab; w.pg = pg; w.fi = fi;
        w.cfg = '0; w.typed = 0; w.res = '0;
        rows.push_back(w);
    endfunction

    function automatic void add_cfg(logic [4:0] v);
        t_row w;
        w.is_cfg = 1; w.mode = plm_pkg::MODE_PIN; w.tab = '0; w.pg = '0; w.fi = '0;
        w.cfg = v; w.typed = 0; w.res = '0;
        rows.push_back(w);
    endfunction

    initial begin
        int burst;
        plm_pkg::t_mode m;
        logic [7:0] tab;
        logic [23:0] pg;
        pool_size = plm_pkg::FIU_RESET;
        temp_slot = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        add_item(plm_pkg::MODE_PIN, 8'd0, 24'd0, 4'd0);
        rows[$].typed = 1; rows[$].res.frame = 4'd0;
        add_item(plm_pkg::MODE_PIN, 8'hFF, 24'hFFFFFF, 4'd0);
        rows[$].typed = 1; rows[$].res.frame = 4'd1;
        add_item(plm_pkg::MODE_PIN, 8'd0, 24'd0, 4'd0);
        rows[$].typed = 1; rows[$].res.frame = 4'd0; rows[$].res.hit = 1;
        add_item(plm_pkg::MODE_TEMP, 8'hA5, 24'h5A5A5A, 4'd0);
        rows[$].typed = 1; rows[$].res.frame = 4'd2;
        // unpin of an empty frame is ignored but echoed
        add_item(plm_pkg::MODE_UNPIN, 8'd0, 24'd0, 4'd15);
        rows[$].typed = 1; rows[$].res.frame = 4'd15;
        add_item(plm_pkg::MODE_DIRTY, 8'd0, 24'd0, 4'd1);
        add_item(plm_pkg::MODE_UNPIN, 8'd0, 24'd0, 4'd1);
        add_item(plm_pkg::MODE_UNPIN, 8'd0, 24'd0, 4'd1);
        add_item(plm_pkg::MODE_UNPIN, 8'd0, 24'd0, 4'd2);
        add_cfg(5'd3);
        add_item(plm_pkg::MODE_PIN, 8'd7, 24'd9, 4'd0);
        add_item(plm_pkg::MODE_PIN, 8'd7, 24'd10, 4'd0);
        add_item(plm_pkg::MODE_TEMP, 8'd0, 24'd0, 4'd0);
        add_cfg(5'd0);
        // frame 0 pinned, pool of one: nothing can be freed
        add_item(plm_pkg::MODE_PIN, 8'd1, 24'd1, 4'd0);
        rows[$].typed = 1; rows[$].res.all_pinned = 1;
        add_item(plm_pkg::MODE_PIN, 8'hFF, 24'hFFFFFF, 4'd0);
        add_item(plm_pkg::MODE_UNPIN, 8'd0, 24'd0, 4'd0);
        add_item(plm_pkg::MODE_TEMP, 8'd0, 24'd0, 4'd0);
        add_cfg(5'd31);
        add_item(plm_pkg::MODE_PIN, 8'd3, 24'h800000, 4'd0);
        add_cfg(5'd16);

        foreach (rows[k]) begin
            if (rows[k].is_cfg) write_pool_size(rows[k].cfg);
            else send_item(rows[k].mode, rows[k].tab, rows[k].pg, rows[k].fi,
                           rows[k].typed, rows[k].res, 1'($urandom_range(0, 1)));
        end

        // random part: small key space so hits and evictions are common
        burst = $urandom_range(1, 12);
        for (int n = 0; n < N_RAND; n++) begin
            if (n % 150 == 149) begin
                case ($urandom_range(0, 5))
                    0: write_pool_size(5'd0);
                    1: write_pool_size(5'd1);
                    2: write_pool_size(5'd31);
                    3: write_pool_size(5'd16);
                    default: write_pool_size(5'($urandom_range(1, 16)));
                endcase
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: m = plm_pkg::MODE_PIN;
                9, 10, 11: m = plm_pkg::MODE_TEMP;
                12, 13, 14, 15, 16, 17: m = plm_pkg::MODE_UNPIN;
                default: m = plm_pkg::MODE_DIRTY;
            endcase
            if ($urandom_range(0, 9) == 0) begin
                tab = 8'($urandom);
                pg = 24'($urandom);
            end else begin
                tab = 8'($urandom_range(0, 3));
                pg = 24'($urandom_range(0, 7));
            end
            burst--;
            send_item(m, tab, pg, 4'($urandom_range(0, 15)), 1'b0, '0, burst == 0);
            if (burst == 0) burst = $urandom_range(1, 12);
        end

        wait_idle();
        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
